// ===== rtl/etp_pkg.sv =====
// ----------------------------------------------------------------------------
// etp_pkg
// Shared types, widths and constants of the exposure time predictor.
// ----------------------------------------------------------------------------
`default_nettype none

package etp_pkg;

  localparam int SLOPE_FRACTION_BITS = 8;

  localparam int CMD_W   = 2;
  localparam int PULSE_W = 16;
  localparam int MS_W    = 8;
  localparam int ET_W    = 17;
  localparam int CFG_W   = 16;
  localparam int OFS_W   = 13;
  localparam int PRED_W  = 14;
  localparam int IDX_W   = 3;

  localparam logic [PRED_W-1:0] PRED_LIMIT = PRED_W'(9999);

  // divider datapath widths
  localparam int PRD_W  = CFG_W + ET_W;
  localparam int SP_W   = PULSE_W + SLOPE_FRACTION_BITS;
  localparam int DEN_W  = ((SP_W > PRD_W) ? SP_W : PRD_W) + 1;
  localparam int NUM_W  = PRD_W + SLOPE_FRACTION_BITS;
  localparam int N_W    = (((NUM_W + 1) > DEN_W) ? (NUM_W + 1) : DEN_W) + 1;
  localparam int D_W    = DEN_W + 1;
  localparam int QB     = PRED_W;
  localparam int QCNT_W = $clog2(QB);
  localparam int NH_W   = N_W - QB;
  localparam int CMP_W  = (NH_W > D_W) ? NH_W : D_W;
  localparam int P_W    = CFG_W + 1;

  // job queue
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  typedef enum logic [CMD_W-1:0] {
    CMD_OFF    = 2'd0,
    CMD_AUTO   = 2'd1,
    CMD_MANUAL = 2'd2,
    CMD_SILENT = 2'd3
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_TARGET   = 3'd0,
    REG_INTERVAL = 3'd1,
    REG_HANDICAP = 3'd2,
    REG_OFFSET   = 3'd3,
    REG_MIN      = 3'd4,
    REG_MAX      = 3'd5,
    REG_WARNING  = 3'd6
  } reg_idx_t;

  typedef struct packed {
    logic [CFG_W-1:0]        compare_target;
    logic [CFG_W-1:0]        interval_ms;
    logic [CFG_W-1:0]        slope_handicap;
    logic signed [OFS_W-1:0] prediction_offset;
    logic [CFG_W-1:0]        min_ms;
    logic [CFG_W-1:0]        max_ms;
    logic [CFG_W-1:0]        warning_ms;
  } cfg_t;

  typedef struct packed {
    logic               do_div;
    cmd_t               cmd;
    logic [PULSE_W-1:0] pulses;
    logic [ET_W-1:0]    elapsed;
  } job_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_MUL,
    BK_PREP,
    BK_CHK,
    BK_DIV,
    BK_DONE
  } bk_state_t;

endpackage

`default_nettype wire

// ===== rtl/exposure_time_predictor_top.sv =====
// ----------------------------------------------------------------------------
// exposure_time_predictor_top
// Light meter: window totals of sensor pulses and time, predicted time to
// reach the target count, and indicator lamps.
//
//   channel  ports                                       direction
//   in       in_valid/in_ready, command, pulse, ms       beat in
//   out      out_valid/out_ready, lamps, prediction      beat out
//   cfg      cfg_valid/cfg_ready, cfg_index, cfg_data    register write
//
// A beat that closes no window is queued, then sets the registered out_valid.
// A closing beat goes through BK_MUL, BK_PREP, BK_CHK, the 14 step restoring
// divider and BK_DONE, skipping the divider on quotient overflow or zero divisor.
// Until full, the two entry queue takes beats as the divider runs or out stalls.
// Reset is synchronous; no clearing pass. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module exposure_time_predictor_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [etp_pkg::CMD_W-1:0]   in_command,
  input  wire logic [etp_pkg::PULSE_W-1:0] in_pulse_count,
  input  wire logic [etp_pkg::MS_W-1:0]    in_ms_elapsed,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output logic                             out_lamps_update,
  output logic                             out_lamp_one,
  output logic                             out_lamp_two,
  output logic                             out_prediction_ready,
  output logic [etp_pkg::PRED_W-1:0]       out_predicted_ms,
  input  wire logic                        cfg_valid,
  output logic                             cfg_ready,
  input  wire logic [etp_pkg::IDX_W-1:0]   cfg_index,
  input  wire logic [etp_pkg::CFG_W-1:0]   cfg_data
);
  import etp_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  job_t push_data, pop_data;
  logic push, pop, full, empty;

  assign cfg_ready = 1'b1;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_TARGET:   cfg_nxt.compare_target    = cfg_data;
        REG_INTERVAL: cfg_nxt.interval_ms       = cfg_data;
        REG_HANDICAP: cfg_nxt.slope_handicap    = cfg_data;
        REG_OFFSET:   cfg_nxt.prediction_offset = $signed(cfg_data[OFS_W-1:0]);
        REG_MIN:      cfg_nxt.min_ms            = cfg_data;
        REG_MAX:      cfg_nxt.max_ms            = cfg_data;
        REG_WARNING:  cfg_nxt.warning_ms        = cfg_data;
        default:      cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.compare_target    <= '0;
      cfg_r.interval_ms       <= CFG_W'(1);
      cfg_r.slope_handicap    <= '0;
      cfg_r.prediction_offset <= '0;
      cfg_r.min_ms            <= '0;
      cfg_r.max_ms            <= '0;
      cfg_r.warning_ms        <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  etp_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_command     (in_command),
    .in_pulse_count (in_pulse_count),
    .in_ms_elapsed  (in_ms_elapsed),
    .interval_ms    (cfg_r.interval_ms),
    .push           (push),
    .push_data      (push_data),
    .full           (full)
  );

  etp_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (full),
    .pop       (pop),
    .pop_data  (pop_data),
    .empty     (empty)
  );

  etp_back u_back (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cfg                  (cfg_r),
    .job                  (pop_data),
    .empty                (empty),
    .pop                  (pop),
    .out_valid            (out_valid),
    .out_ready            (out_ready),
    .out_lamps_update     (out_lamps_update),
    .out_lamp_one         (out_lamp_one),
    .out_lamp_two         (out_lamp_two),
    .out_prediction_ready (out_prediction_ready),
    .out_predicted_ms     (out_predicted_ms)
  );

endmodule

`default_nettype wire

// ===== rtl/etp_fifo.sv =====
// ----------------------------------------------------------------------------
// etp_fifo
// Short job queue between the window tracker and the prediction engine.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire etp_pkg::job_t push_data,
  output logic               full,
  input  wire logic          pop,
  output etp_pkg::job_t      pop_data,
  output logic               empty
);
  import etp_pkg::*;

  job_t              mem [Q_DEPTH];
  logic [Q_AW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [Q_AW:0]     count_r, count_nxt;
  logic              do_push, do_pop;

  assign full     = (count_r == (Q_AW+1)'(Q_DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/etp_front.sv =====
// ----------------------------------------------------------------------------
// etp_front
// Takes input beats, keeps the measuring window and its totals, and queues
// one job per beat: a closing window asks for a prediction.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_front (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_ready,
  input  wire logic [etp_pkg::CMD_W-1:0]   in_command,
  input  wire logic [etp_pkg::PULSE_W-1:0] in_pulse_count,
  input  wire logic [etp_pkg::MS_W-1:0]    in_ms_elapsed,
  input  wire logic [etp_pkg::CFG_W-1:0]   interval_ms,
  output logic                             push,
  output etp_pkg::job_t                    push_data,
  input  wire logic                        full
);
  import etp_pkg::*;

  logic               window_open_r, window_open_nxt;
  logic [PULSE_W-1:0] pulse_total_r, pulse_total_nxt;
  logic [ET_W-1:0]    elapsed_total_r, elapsed_total_nxt;
  logic [PULSE_W:0]   psum;
  logic [PULSE_W-1:0] psat;
  logic [ET_W-1:0]    esum;
  logic               accept;
  cmd_t               cmd;

  assign in_ready = !full;
  assign accept   = in_valid && in_ready;
  assign push     = accept;
  assign cmd      = cmd_t'(in_command);

  assign psum = {1'b0, pulse_total_r} + {1'b0, in_pulse_count};
  assign psat = psum[PULSE_W] ? {PULSE_W{1'b1}} : psum[PULSE_W-1:0];
  assign esum = elapsed_total_r + ET_W'(in_ms_elapsed);

  always_comb begin
    window_open_nxt   = window_open_r;
    pulse_total_nxt   = pulse_total_r;
    elapsed_total_nxt = elapsed_total_r;
    push_data.do_div  = 1'b0;
    push_data.cmd     = cmd;
    push_data.pulses  = psat;
    push_data.elapsed = esum;
    if (accept && cmd != CMD_OFF) begin
      if (!window_open_r) begin
        window_open_nxt   = 1'b1;
        pulse_total_nxt   = '0;
        elapsed_total_nxt = '0;
      end else begin
        pulse_total_nxt   = psat;
        elapsed_total_nxt = esum;
        if (esum >= ET_W'(interval_ms)) begin
          window_open_nxt  = 1'b0;
          push_data.do_div = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_open_r   <= 1'b0;
      pulse_total_r   <= '0;
      elapsed_total_r <= '0;
    end else begin
      window_open_r   <= window_open_nxt;
      pulse_total_r   <= pulse_total_nxt;
      elapsed_total_r <= elapsed_total_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/etp_back.sv =====
// ----------------------------------------------------------------------------
// etp_back
// Prediction engine: two multipliers, a 14 step restoring divider with
// saturation, the lamp decision and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module etp_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire etp_pkg::cfg_t cfg,
  input  wire etp_pkg::job_t job,
  input  wire logic          empty,
  output logic               pop,
  output logic               out_valid,
  input  wire logic          out_ready,
  output logic               out_lamps_update,
  output logic               out_lamp_one,
  output logic               out_lamp_two,
  output logic               out_prediction_ready,
  output logic [etp_pkg::PRED_W-1:0] out_predicted_ms
);
  import etp_pkg::*;

  bk_state_t          state_r, state_nxt;
  cmd_t               cmd_r, cmd_nxt;
  logic [PULSE_W-1:0] pulses_r, pulses_nxt;
  logic [ET_W-1:0]    elapsed_r, elapsed_nxt;
  logic [PRD_W-1:0]   prod_t_r, prod_t_nxt;
  logic [PRD_W-1:0]   prod_h_r, prod_h_nxt;
  logic [N_W-1:0]     n_r, n_nxt;
  logic [D_W-1:0]     d_r, d_nxt;
  logic [D_W-1:0]     rem_r, rem_nxt;
  logic [QB-1:0]      nlo_r, nlo_nxt;
  logic [QB-1:0]      q_r, q_nxt;
  logic [QCNT_W-1:0]  cnt_r, cnt_nxt;

  logic               ov_r, ov_nxt;
  logic               upd_r, upd_nxt;
  logic               l1_r, l1_nxt;
  logic               l2_r, l2_nxt;
  logic               rdy_r, rdy_nxt;
  logic [PRED_W-1:0]  pred_r, pred_nxt;

  logic               slot_free;
  logic [DEN_W-1:0]   den;
  logic [NH_W-1:0]    nh;
  logic [D_W:0]       trial;
  logic [D_W:0]       diff;
  logic [PRED_W-1:0]  pred;
  logic signed [P_W-1:0] p_val;
  logic signed [P_W-1:0] min_s;
  logic signed [P_W-1:0] max_s;

  assign slot_free = !ov_r || out_ready;
  assign den   = DEN_W'({pulses_r, {SLOPE_FRACTION_BITS{1'b0}}}) + DEN_W'(prod_h_r);
  assign nh    = n_r[N_W-1:QB];
  assign trial = {rem_r, nlo_r[QB-1]};
  assign diff  = trial - {1'b0, d_r};
  assign pred  = (q_r > PRED_LIMIT) ? PRED_LIMIT : q_r;
  assign p_val = $signed(P_W'(pred)) + P_W'(cfg.prediction_offset);
  assign min_s = $signed({1'b0, cfg.min_ms});
  assign max_s = $signed({1'b0, cfg.max_ms});

  always_comb begin
    state_nxt   = state_r;
    cmd_nxt     = cmd_r;
    pulses_nxt  = pulses_r;
    elapsed_nxt = elapsed_r;
    prod_t_nxt  = prod_t_r;
    prod_h_nxt  = prod_h_r;
    n_nxt       = n_r;
    d_nxt       = d_r;
    rem_nxt     = rem_r;
    nlo_nxt     = nlo_r;
    q_nxt       = q_r;
    cnt_nxt     = cnt_r;
    ov_nxt      = ov_r && !out_ready;
    upd_nxt     = upd_r;
    l1_nxt      = l1_r;
    l2_nxt      = l2_r;
    rdy_nxt     = rdy_r;
    pred_nxt    = pred_r;
    pop         = 1'b0;
    unique case (state_r)
      BK_IDLE: begin
        if (!empty) begin
          if (job.do_div) begin
            pop         = 1'b1;
            cmd_nxt     = job.cmd;
            pulses_nxt  = job.pulses;
            elapsed_nxt = job.elapsed;
            state_nxt   = BK_MUL;
          end else if (slot_free) begin
            pop      = 1'b1;
            ov_nxt   = 1'b1;
            upd_nxt  = (job.cmd == CMD_OFF);
            l1_nxt   = 1'b0;
            l2_nxt   = 1'b0;
            rdy_nxt  = 1'b0;
            pred_nxt = '0;
          end
        end
      end
      BK_MUL: begin
        prod_t_nxt = PRD_W'(cfg.compare_target) * PRD_W'(elapsed_r);
        prod_h_nxt = PRD_W'(cfg.slope_handicap) * PRD_W'(elapsed_r);
        state_nxt  = BK_PREP;
      end
      BK_PREP: begin
        // N = 2*num + den, D = 2*den gives round half up
        n_nxt     = N_W'({prod_t_r, {SLOPE_FRACTION_BITS{1'b0}}, 1'b0}) + N_W'(den);
        d_nxt     = {den, 1'b0};
        state_nxt = BK_CHK;
      end
      BK_CHK: begin
        if (d_r == '0 || CMP_W'(nh) >= CMP_W'(d_r)) begin
          q_nxt     = PRED_LIMIT;
          state_nxt = BK_DONE;
        end else begin
          rem_nxt   = D_W'(nh);
          nlo_nxt   = n_r[QB-1:0];
          q_nxt     = '0;
          cnt_nxt   = QCNT_W'(QB - 1);
          state_nxt = BK_DIV;
        end
      end
      BK_DIV: begin
        if (!diff[D_W]) begin
          rem_nxt = diff[D_W-1:0];
          q_nxt   = {q_r[QB-2:0], 1'b1};
        end else begin
          rem_nxt = trial[D_W-1:0];
          q_nxt   = {q_r[QB-2:0], 1'b0};
        end
        nlo_nxt = {nlo_r[QB-2:0], 1'b0};
        cnt_nxt = cnt_r - 1'b1;
        if (cnt_r == '0) begin
          state_nxt = BK_DONE;
        end
      end
      BK_DONE: begin
        if (slot_free) begin
          ov_nxt   = 1'b1;
          rdy_nxt  = 1'b1;
          pred_nxt = pred;
          upd_nxt  = 1'b0;
          l1_nxt   = 1'b0;
          l2_nxt   = 1'b0;
          unique case (cmd_r)
            CMD_MANUAL: begin
              upd_nxt = 1'b1;
              if (p_val <= max_s && p_val >= min_s) begin
                l1_nxt = 1'b1;
                l2_nxt = 1'b1;
              end else if (p_val < min_s) begin
                l2_nxt = 1'b1;
              end else begin
                l1_nxt = 1'b1;
              end
            end
            CMD_AUTO: begin
              upd_nxt = 1'b1;
              l1_nxt  = ({2'b0, pred} >= cfg.warning_ms);
            end
            CMD_OFF, CMD_SILENT: begin
              upd_nxt = 1'b0;
            end
          endcase
          state_nxt = BK_IDLE;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= BK_IDLE;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r     <= cmd_nxt;
    pulses_r  <= pulses_nxt;
    elapsed_r <= elapsed_nxt;
    prod_t_r  <= prod_t_nxt;
    prod_h_r  <= prod_h_nxt;
    n_r       <= n_nxt;
    d_r       <= d_nxt;
    rem_r     <= rem_nxt;
    nlo_r     <= nlo_nxt;
    q_r       <= q_nxt;
    cnt_r     <= cnt_nxt;
    upd_r     <= upd_nxt;
    l1_r      <= l1_nxt;
    l2_r      <= l2_nxt;
    rdy_r     <= rdy_nxt;
    pred_r    <= pred_nxt;
  end

  assign out_valid            = ov_r;
  assign out_lamps_update     = upd_r;
  assign out_lamp_one         = l1_r;
  assign out_lamp_two         = l2_r;
  assign out_prediction_ready = rdy_r;
  assign out_predicted_ms     = pred_r;

  a_pred_limit: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r |-> pred_r <= PRED_LIMIT)
    else $error("prediction above limit");

  a_pred_zero: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !rdy_r |-> pred_r == '0)
    else $error("prediction without closed window");

  a_lamps_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && !upd_r |-> !l1_r && !l2_r)
    else $error("lamps lit without update");

  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == BK_DIV |-> rem_r < d_r)
    else $error("divider remainder out of range");

endmodule

`default_nettype wire
